### sv/obme_pkg.sv
// Shared types and codes for the order book match engine.
// No dependencies; imported by every module of the block.
package obme_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_MATCH  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic SIDE_ASK = 1'b0;
  localparam logic SIDE_BID = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic        side;
    logic [7:0]  product_id;
    logic [31:0] time_slot;
    logic [31:0] price;
    logic [31:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sale_price;
    logic [31:0] sale_amount;
    logic        sale_valid;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        side;
    logic [7:0]  product;
    logic [31:0] time_slot;
    logic [31:0] price;
    logic [31:0] amount;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic ins_we;
    logic start;
    logic rd_en;
    logic load_ask;
    logic take_sale;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ask_ok;
    logic bid_hit;
    logic ask_done;
    logic out_free;
    logic pend_valid;
  } sts_t;

endpackage

### sv/obme_ctrl.sv
// Sequencer for the order book: table fill count, ask and bid walk indices.
// Depends on obme_pkg.
module obme_ctrl #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        in_op_i,
  input  obme_pkg::sts_t                    sts_i,
  output obme_pkg::cmd_t                    cmd_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]    rd_idx_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]    wr_idx_o
);
  import obme_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_A_RD, S_A_EV, S_B_RD, S_B_EV, S_FIN
  } state_e;

  state_e        state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [IW-1:0] a_q, a_d, b_q, b_d;
  logic          acc, a_last, b_last;

  assign acc    = in_valid_i && in_ready_o;
  assign a_last = (FW'(a_q) + FW'(1)) == fill_q;
  assign b_last = (FW'(b_q) + FW'(1)) == fill_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign wr_idx_o   = fill_q[IW-1:0];
  assign rd_idx_o   = (state_q == S_A_RD) ? a_q : b_q;

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    a_d     = a_q;
    b_d     = b_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          priority if (in_op_i == OP_INSERT) begin
            if (fill_q < FW'(TABLE_DEPTH)) begin
              cmd_o.ins_we = 1'b1;
              fill_d = fill_q + FW'(1);
            end
          end else if (in_op_i == OP_CLEAR) begin
            fill_d = '0;
          end else if (in_op_i == OP_MATCH) begin
            cmd_o.start = 1'b1;
            a_d = '0;
            state_d = (fill_q == '0) ? S_FIN : S_A_RD;
          end else begin
          end
        end
      end
      S_A_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_A_EV;
      end
      S_A_EV: begin
        if (sts_i.ask_ok) begin
          cmd_o.load_ask = 1'b1;
          b_d = '0;
          state_d = S_B_RD;
        end else if (a_last) begin
          state_d = S_FIN;
        end else begin
          a_d = a_q + IW'(1);
          state_d = S_A_RD;
        end
      end
      S_B_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_B_EV;
      end
      S_B_EV: begin
        // a sale may only be taken once the pending result has somewhere to go
        if (!sts_i.bid_hit || sts_i.out_free || !sts_i.pend_valid) begin
          cmd_o.take_sale = sts_i.bid_hit;
          if ((sts_i.bid_hit && sts_i.ask_done) || b_last) begin
            if (a_last) begin
              state_d = S_FIN;
            end else begin
              a_d = a_q + IW'(1);
              state_d = S_A_RD;
            end
          end else begin
            b_d = b_q + IW'(1);
            state_d = S_B_RD;
          end
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      a_q     <= '0;
      b_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      a_q     <= a_d;
      b_q     <= b_d;
    end
  end

endmodule

### sv/obme_dp.sv
// Datapath: order table memory, working bid amounts, ask registers and the
// pending and output result registers. Depends on obme_pkg.
module obme_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  obme_pkg::in_item_t             in_item_i,
  input  obme_pkg::cmd_t                 cmd_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_idx_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_idx_i,
  output obme_pkg::sts_t                 sts_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output obme_pkg::out_item_t            out_item_o
);
  import obme_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  entry_t      mem_q [TABLE_DEPTH];
  logic [31:0] rem_q [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] touched_q;

  entry_t      rd_q;
  logic [31:0] rem_rd_q;
  logic [IW-1:0] eidx_q;

  logic [7:0]  prod_q;
  logic [31:0] slot_q, ask_left_q, ask_price_q;
  out_item_t   pend_q, out_q;
  logic        pend_valid_q, out_valid_q;

  logic        sel, ask_le;
  logic [31:0] bl, sale;

  assign sel    = (rd_q.product == prod_q) && (rd_q.time_slot == slot_q);
  // a bid not yet traded this run still has its stored amount
  assign bl     = touched_q[eidx_q] ? rem_rd_q : rd_q.amount;
  assign ask_le = ask_left_q <= bl;
  assign sale   = ask_le ? ask_left_q : bl;

  assign sts_o.ask_ok     = sel && (rd_q.side == SIDE_ASK) && (rd_q.amount != '0);
  assign sts_o.bid_hit    = sel && (rd_q.side == SIDE_BID) && (bl != '0) &&
                            (rd_q.price >= ask_price_q);
  assign sts_o.ask_done   = ask_le;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.pend_valid = pend_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // table and working-amount memories, read, ask, pending and output registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_we) begin
      mem_q[wr_idx_i] <= '{side: in_item_i.side, product: in_item_i.product_id,
                           time_slot: in_item_i.time_slot, price: in_item_i.price,
                           amount: in_item_i.amount};
    end
    if (cmd_i.take_sale) begin
      rem_q[eidx_q] <= bl - sale;
    end
    if (cmd_i.rd_en) begin
      rd_q     <= mem_q[rd_idx_i];
      rem_rd_q <= rem_q[rd_idx_i];
      eidx_q   <= rd_idx_i;
    end
    if (cmd_i.start) begin
      prod_q <= in_item_i.product_id;
      slot_q <= in_item_i.time_slot;
    end
    if (cmd_i.load_ask) begin
      ask_left_q  <= rd_q.amount;
      ask_price_q <= rd_q.price;
    end else if (cmd_i.take_sale) begin
      ask_left_q <= ask_left_q - sale;
    end
    if (cmd_i.take_sale) begin
      pend_q <= '{sale_price: ask_price_q, sale_amount: sale,
                  sale_valid: 1'b1, last: 1'b0};
    end
    if (cmd_i.take_sale && pend_valid_q) begin
      out_q <= pend_q;
    end else if (cmd_i.finish) begin
      out_q <= pend_valid_q ? out_item_t'{sale_price: pend_q.sale_price,
                                          sale_amount: pend_q.sale_amount,
                                          sale_valid: 1'b1, last: 1'b1}
                            : out_item_t'{sale_price: '0, sale_amount: '0,
                                          sale_valid: 1'b0, last: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touched_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        touched_q <= '0;
      end else if (cmd_i.take_sale) begin
        touched_q[eidx_q] <= 1'b1;
      end
      priority if (cmd_i.take_sale) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.finish) begin
        pend_valid_q <= 1'b0;
      end else begin
      end
      if ((cmd_i.take_sale && pend_valid_q) || cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### sv/order_book_match_engine_core.sv
// Order book match engine top level: controller plus datapath.
// Depends on obme_pkg, obme_ctrl, obme_dp.
//
// Input channel (in_valid_i/in_ready_o/in_item_i) takes one beat per command:
// insert, match or clear. Output channel (out_valid_o/out_ready_i/out_item_o)
// carries the results of a match, the final one flagged with last; a match
// without any sale gives one beat with sale_valid low.
// Insert and clear give no beat. A match walks the table with one memory
// read port: each ask is read and evaluated, and for each qualifying ask
// the bids are read and evaluated in turn until the ask is used up, then
// the run is closed.
// Each sale is held back one step so the last flag can be set on it; results
// sit in a single output register, and a stalled receiver holds the walk at
// the next sale until that register is free. in_ready_o is high while no
// match is running, also while the final beat still waits to be taken.
// Reset empties the table (fill count to zero) and clears the output; the
// table memory itself is not swept, entries beyond the fill count are never
// read.
module order_book_match_engine_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  obme_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output obme_pkg::out_item_t out_item_o
);
  import obme_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] rd_idx, wr_idx;

  obme_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_op_i    (in_item_i.op),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rd_idx_o   (rd_idx),
    .wr_idx_o   (wr_idx)
  );

  obme_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .rd_idx_i    (rd_idx),
    .wr_idx_i    (wr_idx),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### sv/obme_checker.sv
// Port-level checks for the order book match engine, bound to the top level.
// Depends on obme_pkg and order_book_match_engine_core.
module obme_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input obme_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input obme_pkg::out_item_t out_item_o
);
  import obme_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output beat changed while stalled");

  a_nosale_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.sale_valid |-> out_item_o.last)
    else $error("no-sale beat without last");

  a_match_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.op == OP_MATCH |=> !in_ready_o)
    else $error("input taken during a match run");

  a_insert_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_item_i.op == OP_INSERT ||
      in_item_i.op == OP_CLEAR) |=> in_ready_o)
    else $error("insert or clear did not return to idle");

endmodule

bind order_book_match_engine_core obme_checker u_obme_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

### tb/tb_top.sv
// Self-checking testbench for order_book_match_engine_core: a directed table, then
// random order books, insert/match/clear beats checked against a behavioural book model.
// Depends on obme_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
  import obme_pkg::*;

  localparam int  DEPTH       = 64;
  localparam int  SALE_CAP    = 63;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct {
    in_item_t  cmd;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // book model
  entry_t      book_entry [DEPTH];
  bit          book_used  [DEPTH];
  int          book_fill;
  out_item_t   sales_due  [$];

  int err_cnt;
  int beats_sent;
  int cycle_cnt;
  int src_idle_pct;
  int sink_stall_pct;

  order_book_match_engine_core #(.TABLE_DEPTH(DEPTH)) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t mk_cmd(logic [1:0] op, logic side, logic [7:0] prod,
                                      logic [31:0] slot, logic [31:0] price,
                                      logic [31:0] amt);
    in_item_t c;
    c.op = op; c.side = side; c.product_id = prod;
    c.time_slot = slot; c.price = price; c.amount = amt;
    return c;
  endfunction

  function automatic out_item_t mk_sale(logic [31:0] price, logic [31:0] amt,
                                        logic valid, logic last);
    out_item_t r;
    r.sale_price = price; r.sale_amount = amt; r.sale_valid = valid; r.last = last;
    return r;
  endfunction

  function automatic bit book_pick(int i, logic side, logic [7:0] prod, logic [31:0] slot);
    return book_used[i] && book_entry[i].side == side &&
           book_entry[i].product == prod && book_entry[i].time_slot == slot;
  endfunction

  // Apply one accepted command to the book; sales of a match come back in run
  function automatic void book_apply(in_item_t c, ref out_item_t run [$]);
    logic [31:0] bid_left [DEPTH];
    logic [31:0] ask_left;
    logic [31:0] ask_px;
    bit          capped;
    run.delete();
    case (c.op)
      OP_INSERT: begin
        if (book_fill < DEPTH) begin
          book_used[book_fill] = 1'b1;
          book_entry[book_fill].side = c.side;
          book_entry[book_fill].product = c.product_id;
          book_entry[book_fill].time_slot = c.time_slot;
          book_entry[book_fill].price = c.price;
          book_entry[book_fill].amount = c.amount;
          book_fill++;
        end
      end
      OP_CLEAR: begin
        foreach (book_used[i]) book_used[i] = 1'b0;
        book_fill = 0;
      end
      OP_MATCH: begin
        capped = 1'b0;
        foreach (bid_left[b]) bid_left[b] = book_entry[b].amount;
        for (int a = 0; a < DEPTH && !capped; a++) begin
          if (!book_pick(a, SIDE_ASK, c.product_id, c.time_slot)) continue;
          ask_left = book_entry[a].amount;
          ask_px   = book_entry[a].price;
          for (int b = 0; b < DEPTH && ask_left != 0; b++) begin
            if (!book_pick(b, SIDE_BID, c.product_id, c.time_slot)) continue;
            if (bid_left[b] == 0 || book_entry[b].price < ask_px) continue;
            if (run.size() >= SALE_CAP) begin
              capped = 1'b1;
              break;
            end
            if (ask_left <= bid_left[b]) begin
              run = {run, mk_sale(ask_px, ask_left, 1'b1, 1'b0)};
              bid_left[b] -= ask_left;
              ask_left = 0;
            end else begin
              run = {run, mk_sale(ask_px, bid_left[b], 1'b1, 1'b0)};
              ask_left -= bid_left[b];
              bid_left[b] = 0;
            end
          end
        end
        if (run.size() == 0) run = {run, mk_sale('0, '0, 1'b0, 1'b1)};
        else run[run.size()-1].last = 1'b1;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Idle mix follows the beat count: receiver-heavy, then sender-heavy, then none
  function automatic void set_idling();
    if (beats_sent < 37) begin
      src_idle_pct = 30; sink_stall_pct = 67;
    end else if (beats_sent < 74) begin
      src_idle_pct = 67; sink_stall_pct = 30;
    end else begin
      src_idle_pct = 0; sink_stall_pct = 0;
    end
  endfunction

  task automatic send_cmd(in_item_t c, bit typed = 1'b0, out_item_t want = '0);
    out_item_t run [$];
    set_idling();
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= c;
    do @(posedge clk); while (!in_ready);
    book_apply(c, run);
    if (typed) sales_due = {sales_due, want};
    else foreach (run[i]) sales_due = {sales_due, run[i]};
    if (c.op != OP_SPARE) beats_sent++;
  endtask

  task automatic hold_off();
    in_valid <= 1'b0;
    while (sales_due.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, compare each beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (sales_due.size() == 0) begin
        report_mismatch("unexpected beat", out_item.sale_amount, '0);
      end else begin
        out_item_t exp_beat;
        exp_beat = sales_due.pop_front();
        if (out_item.sale_price !== exp_beat.sale_price)
          report_mismatch("sale_price", out_item.sale_price, exp_beat.sale_price);
        if (out_item.sale_amount !== exp_beat.sale_amount)
          report_mismatch("sale_amount", out_item.sale_amount, exp_beat.sale_amount);
        if (out_item.sale_valid !== exp_beat.sale_valid)
          report_mismatch("sale_valid", out_item.sale_valid, exp_beat.sale_valid);
        if (out_item.last !== exp_beat.last)
          report_mismatch("last", out_item.last, exp_beat.last);
      end
    end
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic run_directed();
    dir_row_t rows [$];
    dir_row_t r;
    // empty book, spare op, one exact fill, zero amounts, partial fills, clear
    r.typed = 1; r.want = mk_sale('0, '0, 1'b0, 1'b1);
    r.cmd = mk_cmd(OP_MATCH, 1'b0, 8'h00, 32'h0, 32'h0, 32'h0); rows = {rows, r};
    r.typed = 0;
    r.cmd = mk_cmd(OP_SPARE, 1'b1, 8'hff, '1, '1, '1); rows = {rows, r};
    r.cmd = mk_cmd(OP_INSERT, SIDE_ASK, 8'h00, 32'h0, 32'h0001_0000, 32'h0002_0000);
    rows = {rows, r};
    r.cmd = mk_cmd(OP_INSERT, SIDE_BID, 8'h00, 32'h0, 32'hffff_ffff, 32'h0002_0000);
    rows = {rows, r};
    r.typed = 1; r.want = mk_sale(32'h0001_0000, 32'h0002_0000, 1'b1, 1'b1);
    r.cmd = mk_cmd(OP_MATCH, 1'b0, 8'h00, 32'h0, 32'h0, 32'h0); rows = {rows, r};
    r.typed = 0;
    r.cmd = mk_cmd(OP_INSERT, SIDE_ASK, 8'hff, '1, 32'h0, 32'h0); rows = {rows, r};
    r.cmd = mk_cmd(OP_INSERT, SIDE_BID, 8'hff, '1, '1, 32'h0); rows = {rows, r};
    r.typed = 1; r.want = mk_sale('0, '0, 1'b0, 1'b1);
    r.cmd = mk_cmd(OP_MATCH, 1'b1, 8'hff, '1, '1, '1); rows = {rows, r};
    r.typed = 0;
    r.cmd = mk_cmd(OP_INSERT, SIDE_ASK, 8'hff, '1, 32'h0000_8000, '1); rows = {rows, r};
    r.cmd = mk_cmd(OP_INSERT, SIDE_BID, 8'hff, '1, 32'h0000_7fff, 32'h0000_0100);
    rows = {rows, r};
    r.cmd = mk_cmd(OP_INSERT, SIDE_BID, 8'hff, '1, 32'h0000_8000, 32'h0000_0001);
    rows = {rows, r};
    r.cmd = mk_cmd(OP_INSERT, SIDE_BID, 8'hff, '1, '1, 32'h0000_0005); rows = {rows, r};
    r.cmd = mk_cmd(OP_MATCH, 1'b1, 8'hff, '1, 32'h1234_5678, 32'h9abc_def0);
    rows = {rows, r};
    // ask smaller than bid: bid keeps the rest for the second ask
    r.cmd = mk_cmd(OP_INSERT, SIDE_BID, 8'h5a, 32'h8000_0001, 32'h0010_0000, 32'h0003_0000);
    rows = {rows, r};
    r.cmd = mk_cmd(OP_INSERT, SIDE_ASK, 8'h5a, 32'h8000_0001, 32'h000f_0000, 32'h0001_0000);
    rows = {rows, r};
    r.cmd = mk_cmd(OP_INSERT, SIDE_ASK, 8'h5a, 32'h8000_0001, 32'h0010_0000, 32'h0004_0000);
    rows = {rows, r};
    r.cmd = mk_cmd(OP_MATCH, 1'b0, 8'h5a, 32'h8000_0001, 32'h0, 32'h0); rows = {rows, r};
    r.cmd = mk_cmd(OP_CLEAR, 1'b1, 8'h5a, 32'h8000_0001, '1, '1); rows = {rows, r};
    r.typed = 1; r.want = mk_sale('0, '0, 1'b0, 1'b1);
    r.cmd = mk_cmd(OP_MATCH, 1'b0, 8'h5a, 32'h8000_0001, 32'h0, 32'h0); rows = {rows, r};
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);
  endtask

  // Full table: one ask against 63 bids hits the sale cap, then inserts are dropped
  task automatic run_full_book();
    logic [7:0]  prod;
    logic [31:0] slot;
    logic [31:0] px;
    prod = 8'($urandom);
    slot = $urandom;
    px   = $urandom_range(32'h00ff_ffff);
    send_cmd(mk_cmd(OP_CLEAR, 1'($urandom), 8'($urandom), $urandom, $urandom, $urandom));
    send_cmd(mk_cmd(OP_INSERT, SIDE_ASK, prod, slot, px, '1));
    for (int i = 0; i < DEPTH - 1; i++)
      send_cmd(mk_cmd(OP_INSERT, SIDE_BID, prod, slot, px + $urandom_range(255),
                      $urandom_range(1, 32'hffff)));
    send_cmd(mk_cmd(OP_MATCH, 1'($urandom), prod, slot, $urandom, $urandom));
    send_cmd(mk_cmd(OP_INSERT, SIDE_ASK, prod ^ 8'h01, slot, 32'h0, 32'h100));
    send_cmd(mk_cmd(OP_INSERT, SIDE_BID, prod ^ 8'h01, slot, '1, 32'h100));
    send_cmd(mk_cmd(OP_MATCH, 1'($urandom), prod ^ 8'h01, slot, $urandom, $urandom));
  endtask

  // Small book on two products and two slots, prices clustered so they cross
  task automatic run_small_book();
    logic [7:0]  prods [2];
    logic [31:0] slots [2];
    logic [31:0] base;
    logic [31:0] amt;
    int          n_ord;
    prods[0] = 8'($urandom); prods[1] = 8'($urandom);
    slots[0] = $urandom; slots[1] = $urandom;
    base = $urandom;
    if ($urandom_range(3) == 0) hold_off();
    send_cmd(mk_cmd(OP_CLEAR, 1'($urandom), 8'($urandom), $urandom, $urandom, $urandom));
    n_ord = $urandom_range(2, 10);
    for (int i = 0; i < n_ord; i++) begin
      amt = ($urandom_range(7) == 0) ? 32'h0 :
            ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 32'h0004_0000);
      send_cmd(mk_cmd(OP_INSERT, 1'($urandom), prods[$urandom_range(1)],
                      slots[$urandom_range(1)], base + $urandom_range(32), amt));
      if ($urandom_range(9) == 0)
        send_cmd(mk_cmd(2'($urandom), 1'($urandom), 8'($urandom), $urandom, $urandom,
                        $urandom));
    end
    repeat ($urandom_range(1, 2))
      send_cmd(mk_cmd(OP_MATCH, 1'($urandom), prods[$urandom_range(1)],
                      slots[$urandom_range(1)], $urandom, $urandom));
  endtask

  initial begin
    int rnd_start;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_ready = 1'b0;
    err_cnt   = 0;
    beats_sent = 0;
    cycle_cnt = 0;
    src_idle_pct = 30;
    sink_stall_pct = 67;
    book_fill = 0;
    foreach (book_used[i]) book_used[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    hold_off();
    rnd_start = beats_sent;
    run_full_book();
    while (beats_sent - rnd_start < 92) run_small_book();

    in_valid <= 1'b0;
    while (sales_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (err_cnt == 0 && sales_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/obme_pkg.sv
sv/obme_ctrl.sv
sv/obme_dp.sv
sv/order_book_match_engine_core.sv
sv/obme_checker.sv
tb/tb_top.sv
